/* hdl/bpfa_pkg.sv */
// shared types, constants and defaults of the bitmap page frame allocator
`timescale 1ns / 1ps

package bpfa_pkg;

	// geometry defaults
	localparam int NUM_PAGES_DEF      = 256;
	localparam int PREFETCH_DEPTH_DEF = 20;

	// page size is fixed: the address math uses it as a shift
	localparam int PAGE_BYTES = 4096;
	localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);

	// bitmap is held in words of this many page bits
	localparam int WORD_BITS = 32;
	localparam int BIT_W     = $clog2(WORD_BITS);

	localparam int ADDR_W = 32;

	// request codes
	localparam logic [1:0] ACT_ALLOC = 2'd0;
	localparam logic [1:0] ACT_FREE  = 2'd1;
	localparam logic [1:0] ACT_CLEAR = 2'd2;

	typedef struct packed {
		logic [1:0]        action;
		logic [ADDR_W-1:0] frame_addr;
	} req_t;

	typedef struct packed {
		logic [ADDR_W-1:0] alloc_addr;
		logic              failed;
	} res_t;

	// answer of the free-bit picker for the current bitmap word
	typedef struct packed {
		logic              found;
		logic [BIT_W-1:0]  bit_pos;
		logic [ADDR_W-1:0] addr;
	} pick_t;

endpackage

/* hdl/bpfa_ram.sv */
// generic single-port-write, registered-read ram
`timescale 1ns / 1ps

module bpfa_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* hdl/bpfa_pick.sv */
// lowest free bit of one bitmap word and the byte address of that page
`timescale 1ns / 1ps

module bpfa_pick
	import bpfa_pkg::*;
#(
	parameter int WI_W = 3
) (
	input  logic [WORD_BITS-1:0] word,
	input  logic [WI_W-1:0]      word_idx,
	input  logic [ADDR_W-1:0]    heap_base,
	output pick_t                pick
);

	logic [BIT_W-1:0]      pos;
	logic                  found;
	logic [WI_W+BIT_W-1:0] page_idx;

	// priority encoder, lowest clear bit wins
	always_comb begin
		pos   = '0;
		found = 1'b0;
		for (int b = WORD_BITS - 1; b >= 0; b--) begin
			if (!word[b]) begin
				pos   = BIT_W'(b);
				found = 1'b1;
			end
		end
	end

	assign page_idx     = {word_idx, pos};
	assign pick.found   = found;
	assign pick.bit_pos = pos;
	assign pick.addr    = heap_base + (ADDR_W'(page_idx) << PAGE_SHIFT);

endmodule

/* hdl/bitmap_page_frame_allocator.sv */
// top level: sequencer, bitmap and prefetch memories of the page frame allocator
`timescale 1ns / 1ps

//  channel   signals                         direction  accepted when
//  request   start, busy, req                in         start && !busy
//  result    done, result                    out        every cycle done is high
//  config    cfg_valid, cfg_ready, cfg_data  in         cfg_valid && cfg_ready
//
// allocate from a filled buffer: accept, buffer read, result beat
// allocate that refills: a word-serial scan reads and loads each bitmap word and fills one
//   buffer entry per free bit taken, then the buffer read and the result beat
// free: word read, word write; unused action: no effect, no result
// clear and reset: the bitmap words, NUM_PAGES/32 rounded up, are zeroed in order while
//   busy is high; configuration writes are taken throughout
// the receiver cannot stall: a result beat shows for one cycle only

module bitmap_page_frame_allocator
	import bpfa_pkg::*;
#(
	parameter int NUM_PAGES      = NUM_PAGES_DEF,
	parameter int PREFETCH_DEPTH = PREFETCH_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  req_t              req,
	output logic              done,
	output res_t              result,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [ADDR_W-1:0] cfg_data
);

	// bitmap geometry
	localparam int NUM_WORDS = (NUM_PAGES + WORD_BITS - 1) / WORD_BITS;
	localparam int WI_W      = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
	localparam int TAIL      = NUM_PAGES % WORD_BITS;
	localparam logic [WI_W-1:0] LAST_WI = WI_W'(NUM_WORDS - 1);
	// bits past the last page look used so the scan never hands them out
	localparam logic [WORD_BITS-1:0] PAD_MASK =
		(TAIL == 0) ? '0 : ~((WORD_BITS'(1) << TAIL) - WORD_BITS'(1));

	// prefetch buffer geometry
	localparam int PF_W = $clog2(PREFETCH_DEPTH + 1);
	localparam int PA_W = (PREFETCH_DEPTH > 1) ? $clog2(PREFETCH_DEPTH) : 1;
	localparam logic [PF_W-1:0] PF_FULL = PF_W'(PREFETCH_DEPTH);
	localparam int ENT_W = ADDR_W + 1;

	// free address decode widths
	localparam int OFS_W = ADDR_W - PAGE_SHIFT;

	typedef enum logic [9:0] {
		S_IDLE    = 10'b00_0000_0001,
		S_CLEAR   = 10'b00_0000_0010,
		S_RD      = 10'b00_0000_0100,
		S_LOAD    = 10'b00_0000_1000,
		S_TAKE    = 10'b00_0001_0000,
		S_FAIL    = 10'b00_0010_0000,
		S_PREAD   = 10'b00_0100_0000,
		S_PRES    = 10'b00_1000_0000,
		S_FREE_RD = 10'b01_0000_0000,
		S_FREE_WR = 10'b10_0000_0000
	} state_t;

	state_t              state_q;
	logic [WI_W-1:0]     wi_q;      // bitmap word under scan, clear or free
	logic [BIT_W-1:0]    fbit_q;    // bit to clear on free
	logic [WORD_BITS-1:0] cur_q;    // working copy of the scanned word
	logic [PF_W-1:0]     fill_q;    // entries written in this refill
	logic [PF_W-1:0]     pos_q;     // next buffer entry to hand out
	logic [ADDR_W-1:0]   heap_base_q;
	res_t                res_q;
	logic                done_q;

	// memory ports
	logic                 bm_we, bm_re;
	logic [WI_W-1:0]      bm_waddr;
	logic [WORD_BITS-1:0] bm_wdata, bm_rdata;
	logic                 pf_we, pf_re;
	logic [PA_W-1:0]      pf_waddr;
	logic [ENT_W-1:0]     pf_wdata, pf_rdata;

	pick_t pick;

	// free request decode
	logic [ADDR_W:0]    free_ofs;
	logic [OFS_W-1:0]   free_page;
	logic               free_ok;

	logic accept;

	assign accept    = start && !busy;
	assign busy      = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;
	assign done      = done_q;
	assign result    = res_q;

	// below-heap shows up as a borrow out of the subtract
	assign free_ofs  = {1'b0, req.frame_addr} - {1'b0, heap_base_q};
	assign free_page = free_ofs[ADDR_W-1:PAGE_SHIFT];
	assign free_ok   = !free_ofs[ADDR_W] && (free_page < OFS_W'(NUM_PAGES));

	bpfa_ram #(
		.WIDTH (WORD_BITS),
		.DEPTH (NUM_WORDS),
		.AW    (WI_W)
	) u_bitmap (
		.clk   (clk),
		.we    (bm_we),
		.waddr (bm_waddr),
		.wdata (bm_wdata),
		.re    (bm_re),
		.raddr (wi_q),
		.rdata (bm_rdata)
	);

	bpfa_ram #(
		.WIDTH (ENT_W),
		.DEPTH (PREFETCH_DEPTH),
		.AW    (PA_W)
	) u_prefetch (
		.clk   (clk),
		.we    (pf_we),
		.waddr (pf_waddr),
		.wdata (pf_wdata),
		.re    (pf_re),
		.raddr (pos_q[PA_W-1:0]),
		.rdata (pf_rdata)
	);

	// shared picker works on the word held in cur_q
	bpfa_pick #(
		.WI_W (WI_W)
	) u_pick (
		.word      (cur_q),
		.word_idx  (wi_q),
		.heap_base (heap_base_q),
		.pick      (pick)
	);

	// memory controls per sequencer state
	always_comb begin
		bm_we    = 1'b0;
		bm_re    = 1'b0;
		bm_waddr = wi_q;
		bm_wdata = cur_q;
		pf_we    = 1'b0;
		pf_re    = 1'b0;
		pf_waddr = fill_q[PA_W-1:0];
		pf_wdata = {1'b0, pick.addr};
		unique case (state_q)
			S_CLEAR: begin
				bm_we    = 1'b1;
				bm_wdata = '0;
			end
			S_RD, S_FREE_RD: begin
				bm_re = 1'b1;
			end
			S_TAKE: begin
				if (fill_q == PF_FULL || !pick.found) begin
					// buffer full or word used up: write the word back
					bm_we = 1'b1;
				end else begin
					pf_we = 1'b1;
				end
			end
			S_FAIL: begin
				pf_we    = (fill_q != PF_FULL);
				pf_wdata = {1'b1, {ADDR_W{1'b0}}};
			end
			S_PREAD: begin
				pf_re = 1'b1;
			end
			S_FREE_WR: begin
				bm_we    = 1'b1;
				bm_wdata = bm_rdata & ~(WORD_BITS'(1) << fbit_q);
			end
			S_IDLE, S_LOAD, S_PRES: begin
			end
			default: begin
			end
		endcase
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heap_base_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			heap_base_q <= cfg_data;
		end
	end

	// result register, payload only
	always_ff @(posedge clk) begin
		if (state_q == S_PRES) begin
			res_q.alloc_addr <= pf_rdata[ADDR_W-1:0];
			res_q.failed     <= pf_rdata[ADDR_W];
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;   // clearing pass over the bitmap after reset
			wi_q    <= '0;
			fbit_q  <= '0;
			fill_q  <= '0;
			pos_q   <= PF_FULL;   // first allocate refills
			done_q  <= 1'b0;
			cur_q   <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						unique case (req.action)
							ACT_ALLOC: begin
								if (pos_q == PF_FULL) begin
									wi_q    <= '0;
									fill_q  <= '0;
									state_q <= S_RD;
								end else begin
									state_q <= S_PREAD;
								end
							end
							ACT_FREE: begin
								if (free_ok) begin
									wi_q    <= free_page[BIT_W +: WI_W];
									fbit_q  <= free_page[BIT_W-1:0];
									state_q <= S_FREE_RD;
								end
							end
							ACT_CLEAR: begin
								wi_q    <= '0;
								state_q <= S_CLEAR;
							end
							default: begin
								// unused code: no effect, no result
							end
						endcase
					end
				end
				S_CLEAR: begin
					if (wi_q == LAST_WI) begin
						state_q <= S_IDLE;
					end else begin
						wi_q <= wi_q + 1'b1;
					end
				end
				S_RD: begin
					state_q <= S_LOAD;
				end
				S_LOAD: begin
					cur_q   <= (wi_q == LAST_WI) ? (bm_rdata | PAD_MASK) : bm_rdata;
					state_q <= S_TAKE;
				end
				S_TAKE: begin
					if (fill_q == PF_FULL) begin
						pos_q   <= '0;
						state_q <= S_PREAD;
					end else if (pick.found) begin
						cur_q[pick.bit_pos] <= 1'b1;
						fill_q              <= fill_q + 1'b1;
					end else if (wi_q == LAST_WI) begin
						// heap full: the rest of this refill gets failure marks
						state_q <= S_FAIL;
					end else begin
						wi_q    <= wi_q + 1'b1;
						state_q <= S_RD;
					end
				end
				S_FAIL: begin
					if (fill_q == PF_FULL) begin
						pos_q   <= '0;
						state_q <= S_PREAD;
					end else begin
						fill_q <= fill_q + 1'b1;
					end
				end
				S_PREAD: begin
					state_q <= S_PRES;
				end
				S_PRES: begin
					pos_q   <= pos_q + 1'b1;
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				S_FREE_RD: begin
					state_q <= S_FREE_WR;
				end
				S_FREE_WR: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// a buffer read always ends in exactly one result beat
	a_pres_done: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_PRES |=> done)
		else $error("buffer read without result beat");

	// a result beat only follows a buffer read
	a_done_src: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == S_PRES))
		else $error("result beat without buffer read");

	// a failed allocation carries a zero address
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.failed |-> result.alloc_addr == '0)
		else $error("failed allocation with nonzero address");

	// an allocate on an exhausted buffer starts a scan from word zero
	a_refill: assert property (@(posedge clk) disable iff (!arst_n)
		accept && req.action == ACT_ALLOC && pos_q == PF_FULL
		|=> state_q == S_RD && wi_q == '0 && fill_q == '0)
		else $error("exhausted buffer did not refill");

	// counters stay within the buffer
	a_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= PF_FULL && pos_q <= PF_FULL)
		else $error("prefetch counter out of range");

endmodule

/* bench/tb_bitmap_page_frame_allocator.sv */
// self-checking bench for the page frame allocator: request driver, result checker, frame map
`timescale 1ns / 1ps

module tb_bitmap_page_frame_allocator
	import bpfa_pkg::*;
();

	// geometry of the instance under test, defaults of the package
	localparam int NUM_PG   = NUM_PAGES_DEF;
	localparam int PF_DEPTH = PREFETCH_DEPTH_DEF;

	// request code the block leaves unused
	localparam logic [1:0] ACT_NONE = 2'd3;

	// failure mark of a prefetch entry sits above the 32-bit address
	localparam logic [32:0] NO_FRAME = 33'h1_0000_0000;

	logic              clk       = 1'b0;
	logic              arst_n    = 1'b0;
	logic              start     = 1'b0;
	req_t              req       = '0;
	logic              cfg_valid = 1'b0;
	logic [ADDR_W-1:0] cfg_data  = '0;
	logic              busy;
	logic              done;
	res_t              result;
	logic              cfg_ready;

	bitmap_page_frame_allocator dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.req       (req),
		.done      (done),
		.result    (result),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always #2 clk = ~clk;

	// requests waiting to be driven, and allocations still owed by the block
	req_t req_backlog[$];
	res_t due_allocs[$];

	// mirror of the allocator state
	bit          pg_taken[NUM_PG];
	logic [32:0] pf_buf[PF_DEPTH];
	int          pf_pos   = PF_DEPTH;
	logic [31:0] map_base = '0;

	int mismatches = 0;
	bit req_taken  = 1'b0;

	// burst shaping of the request side
	int burst_left = 1;
	int gap_left   = 0;

	// refill: each entry takes the lowest free frame, or the failure mark once the map is full
	task automatic refill_prefetch();
		logic [32:0] entry;
		for (int i = 0; i < PF_DEPTH; i++) begin
			entry = NO_FRAME;
			for (int p = 0; p < NUM_PG; p++) begin
				if (!pg_taken[p]) begin
					pg_taken[p] = 1'b1;
					entry = {1'b0, map_base + (32'(p) << PAGE_SHIFT)};
					break;
				end
			end
			pf_buf[i] = entry;
		end
		pf_pos = 0;
	endtask

	// apply one accepted request to the mirror; an allocate owes one result beat
	task automatic predict_request(req_t r);
		logic [32:0] entry;
		logic [31:0] offs;
		logic [31:0] idx;
		res_t        owed;
		case (r.action)
			ACT_ALLOC: begin
				if (pf_pos >= PF_DEPTH)
					refill_prefetch();
				entry = pf_buf[pf_pos];
				pf_pos++;
				owed.failed     = entry[32];
				owed.alloc_addr = entry[32] ? '0 : entry[31:0];
				due_allocs.push_back(owed);
			end
			ACT_FREE: begin
				// below the heap and beyond its last frame are both ignored
				if (r.frame_addr >= map_base) begin
					offs = r.frame_addr - map_base;
					idx  = offs >> PAGE_SHIFT;
					if (idx < NUM_PG)
						pg_taken[idx] = 1'b0;
				end
			end
			ACT_CLEAR: begin
				// prefetched frames stay in the buffer even though now marked free
				for (int p = 0; p < NUM_PG; p++)
					pg_taken[p] = 1'b0;
			end
			default: ;
		endcase
	endtask

	task automatic log_mismatch(string what, logic [31:0] want, logic [31:0] got);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t: %s mismatch: expected %h, got %h", $realtime, what, want, got);
	endtask

	// monitor: result beats are checked first, then the request beat of this edge is predicted
	always @(posedge clk) begin
		res_t want;
		if (arst_n) begin
			if (done) begin
				if (due_allocs.size() == 0) begin
					log_mismatch("unexpected result", '0, result.alloc_addr);
				end else begin
					want = due_allocs.pop_front();
					if (result.alloc_addr !== want.alloc_addr)
						log_mismatch("alloc_addr", want.alloc_addr, result.alloc_addr);
					if (result.failed !== want.failed)
						log_mismatch("failed", 32'(want.failed), 32'(result.failed));
				end
			end
			if (cfg_valid && cfg_ready)
				map_base = cfg_data;
			if (start && !busy)
				predict_request(req);
		end
		req_taken <= arst_n && start && !busy;
	end

	// driver: bursts of back-to-back requests with random gaps; a request is held until taken
	always @(negedge clk) begin
		if (arst_n && !(start && !req_taken)) begin
			if (gap_left > 0) begin
				gap_left <= gap_left - 1;
				start    <= 1'b0;
			end else if (req_backlog.size() > 0) begin
				req   <= req_backlog.pop_front();
				start <= 1'b1;
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 12);
					// about half the bursts run straight into the next one
					gap_left   <= $urandom_range(0, 1) ? $urandom_range(1, 8) : 0;
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				start <= 1'b0;
			end
		end
	end

	task automatic queue_item(logic [1:0] act, logic [31:0] addr);
		req_t r;
		r.action     = act;
		r.frame_addr = addr;
		req_backlog.push_back(r);
	endtask

	// free address: mostly inside the low, busy part of the heap, sometimes out of it
	function automatic logic [31:0] pick_free_addr(logic [31:0] base);
		logic [31:0] offs;
		offs = $urandom_range(0, 1) ? 32'($urandom_range(0, PAGE_BYTES - 1)) : '0;
		case ($urandom_range(0, 9))
			0:       return $urandom();
			1:       return base - 32'($urandom_range(1, 5000));
			2:       return base + (32'(NUM_PG + $urandom_range(0, 40)) << PAGE_SHIFT) + offs;
			3:       return base + (32'($urandom_range(0, NUM_PG - 1)) << PAGE_SHIFT) + offs;
			default: return base + (32'($urandom_range(0, 63)) << PAGE_SHIFT) + offs;
		endcase
	endfunction

	// random requests, mix given in percent; what is left over goes to the unused code
	task automatic queue_random(int n, int p_alloc, int p_free, int p_clear, logic [31:0] base);
		int roll;
		for (int i = 0; i < n; i++) begin
			roll = $urandom_range(0, 99);
			if (roll < p_alloc)
				queue_item(ACT_ALLOC, $urandom());
			else if (roll < p_alloc + p_free)
				queue_item(ACT_FREE, pick_free_addr(base));
			else if (roll < p_alloc + p_free + p_clear)
				queue_item(ACT_CLEAR, $urandom());
			else
				queue_item(ACT_NONE, $urandom());
		end
	endtask

	// wait until every request is in and every owed beat is out, then let the block settle
	task automatic drain();
		while (req_backlog.size() != 0 || start || due_allocs.size() != 0)
			@(negedge clk);
		repeat (40) @(negedge clk);
	endtask

	task automatic write_heap_base(logic [31:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		logic [31:0] base;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;

		// directed: first allocate refills, then the free corner cases and a clear
		base = 32'h1000_0000;
		write_heap_base(base);
		queue_item(ACT_ALLOC, 32'h0000_0000);
		queue_item(ACT_ALLOC, 32'hFFFF_FFFF);
		queue_item(ACT_FREE, base);                           // frame 0
		queue_item(ACT_FREE, base - 1);                       // just below the heap
		queue_item(ACT_FREE, 32'h0000_0000);                  // far below the heap
		queue_item(ACT_FREE, base + (NUM_PG << PAGE_SHIFT));  // first frame past the end
		queue_item(ACT_FREE, 32'hFFFF_FFFF);                  // far beyond the end
		queue_item(ACT_FREE, base + 32'h0000_1ABC);           // unaligned, inside frame 1
		queue_item(ACT_FREE, base + (100 << PAGE_SHIFT));     // frame that is already free
		queue_item(ACT_NONE, 32'hFFFF_FFFF);
		queue_item(ACT_CLEAR, 32'h5A5A_5A5A);                 // clear with a filled buffer
		queue_item(ACT_ALLOC, 32'hA5A5_A5A5);
		queue_random(120, 60, 30, 3, base);
		drain();

		base = 32'h0000_0000;
		write_heap_base(base);
		queue_random(120, 60, 30, 3, base);
		drain();

		// allocate-heavy phase at the top of the address space: wraps and runs the map full
		base = 32'hFFFF_FFFF;
		write_heap_base(base);
		queue_random(280, 90, 6, 0, base);
		drain();

		base = 32'hFFFF_8000;
		write_heap_base(base);
		queue_random(100, 50, 40, 5, base);
		drain();

		base = $urandom();
		write_heap_base(base);
		queue_random(60, 60, 30, 5, base);
		drain();

		if (mismatches == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	// watchdog, far beyond the slowest legal run
	initial begin
		#2_000_000;
		$display("Test completed with failures");
		$finish;
	end

endmodule

/* sim.f */
hdl/bpfa_pkg.sv
hdl/bpfa_ram.sv
hdl/bpfa_pick.sv
hdl/bitmap_page_frame_allocator.sv
bench/tb_bitmap_page_frame_allocator.sv
